// ----- rtl/core/kef_pkg.sv -----
// Shared types and constants for the key event queue.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package kef_pkg;

   localparam int KEY_W            = 32;
   localparam int LIMIT_W          = 7;
   localparam int MAX_DEPTH_DEF    = 64;
   localparam int DOWN_BIT_DEF     = 29;
   localparam int RELEASE_BIT_DEF  = 28;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(7);

   localparam logic CMD_PUT = 1'b0;
   localparam logic CMD_GET = 1'b1;

   // Controller to datapath commands.
   typedef struct packed {
      logic capture;    // latch request payload
      logic execute;    // run put or get, load response registers
      logic cfg_write;  // load limit and flush queue
   } kef_cmd_type;

endpackage

// ----- rtl/core/kef_if.sv -----
// Handshake channel interfaces for request, response and CSR write.
// Depends on kef_pkg.
`timescale 1ns / 1ps

interface kef_req_if;
   logic                     valid;
   logic                     ready;
   logic                     command;
   logic [kef_pkg::KEY_W-1:0] key_code;

   modport source (output valid, output command, output key_code, input ready);
   modport sink   (input valid, input command, input key_code, output ready);
endinterface

interface kef_rsp_if;
   logic                     valid;
   logic                     ready;
   logic                     accepted;
   logic                     key_valid;
   logic [kef_pkg::KEY_W-1:0] key_out;

   modport source (output valid, output accepted, output key_valid, output key_out,
                   input ready);
   modport sink   (input valid, input accepted, input key_valid, input key_out,
                   output ready);
endinterface

interface kef_csr_if;
   logic                       valid;
   logic                       ready;
   logic [kef_pkg::LIMIT_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/key_event_fifo_with_release_reserve.sv -----
// Top level of the key event queue: controller, datapath and channel hookup.
// Depends on kef_pkg, kef_if, kef_ctrl and kef_dp.
`timescale 1ns / 1ps

// Key event queue with a release reserve. Each request is a put or a get and
// produces exactly one response. A transaction passes through the accept
// cycle, an execute cycle (the event RAM read port is registered, so a get's
// data arrives there) and the response state; the next request is taken once
// the response has been handed off, so a new request is never taken while one
// is still in flight. The controller runs one transaction at a time. A CSR
// write of the limit flushes the queue and is taken only while no transaction
// is in flight; it has priority over a request offered in the same cycle. The
// event RAM needs no clearing after reset.

module key_event_fifo_with_release_reserve #(
   parameter int MAX_DEPTH   = kef_pkg::MAX_DEPTH_DEF,
   parameter int DOWN_BIT    = kef_pkg::DOWN_BIT_DEF,
   parameter int RELEASE_BIT = kef_pkg::RELEASE_BIT_DEF
) (
   input  logic      clock,
   input  logic      reset,
   kef_req_if.sink   req_ch,
   kef_rsp_if.source rsp_ch,
   kef_csr_if.sink   csr_ch
);
   import kef_pkg::*;

   kef_cmd_type cmd;

   kef_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .csr_valid (csr_ch.valid),
      .csr_ready (csr_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   kef_dp #(
      .MAX_DEPTH   (MAX_DEPTH),
      .DOWN_BIT    (DOWN_BIT),
      .RELEASE_BIT (RELEASE_BIT)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_command   (req_ch.command),
      .req_key_code  (req_ch.key_code),
      .csr_data      (csr_ch.data),
      .rsp_accepted  (rsp_ch.accepted),
      .rsp_key_valid (rsp_ch.key_valid),
      .rsp_key_out   (rsp_ch.key_out)
   );

endmodule

// ----- rtl/core/kef_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module kef_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/kef_ctrl.sv -----
// Sequencing state machine: accept, execute, hold response.
// Depends on kef_pkg.
`timescale 1ns / 1ps

module kef_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output kef_pkg::kef_cmd_type cmd
);
   import kef_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // CSR write wins over a request in the same cycle.
   assign csr_ready = (state_ff == ST_IDLE);
   assign req_ready = (state_ff == ST_IDLE) && !csr_valid;
   assign rsp_valid = rsp_valid_ff;

   assign cmd.capture   = req_valid && req_ready;
   assign cmd.execute   = (state_ff == ST_EXEC);
   assign cmd.cfg_write = csr_valid && csr_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.capture) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in     = ST_RESP;
            rsp_valid_in = 1'b1;
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b0;
            end
         end
         default: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_exec_to_resp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |=> (state_ff == ST_RESP) && rsp_valid_ff)
      else $error("execute cycle not followed by response");

   a_no_dual_accept: assert property (@(posedge clock) disable iff (reset)
      !(cmd.capture && cmd.cfg_write))
      else $error("request and CSR write accepted together");

endmodule

// ----- rtl/core/kef_dp.sv -----
// Queue datapath: pointers, admission policy, event RAM and response registers.
// Depends on kef_pkg and kef_ram.
`timescale 1ns / 1ps

module kef_dp #(
   parameter int MAX_DEPTH   = kef_pkg::MAX_DEPTH_DEF,
   parameter int DOWN_BIT    = kef_pkg::DOWN_BIT_DEF,
   parameter int RELEASE_BIT = kef_pkg::RELEASE_BIT_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  kef_pkg::kef_cmd_type         cmd,
   input  logic                         req_command,
   input  logic [kef_pkg::KEY_W-1:0]    req_key_code,
   input  logic [kef_pkg::LIMIT_W-1:0]  csr_data,
   output logic                         rsp_accepted,
   output logic                         rsp_key_valid,
   output logic [kef_pkg::KEY_W-1:0]    rsp_key_out
);
   import kef_pkg::*;

   localparam int IDX_W = $clog2(MAX_DEPTH);
   localparam int CNT_W = $clog2(MAX_DEPTH + 1);
   localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
   localparam logic [KEY_W-1:0] DOWN_MASK = KEY_W'(1) << DOWN_BIT;
   localparam logic [KEY_W-1:0] RA_MASK   = KEY_W'(1) << RELEASE_BIT;

   logic [LIMIT_W-1:0] limit_ff;
   logic [IDX_W-1:0]   read_slot_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [KEY_W-1:0]   last_down_ff;
   logic               cmd_ff;
   logic [KEY_W-1:0]   key_ff;
   logic               accepted_ff, accepted_in;
   logic               key_valid_ff, key_valid_in;
   logic [KEY_W-1:0]   key_out_ff, key_out_in;

   logic [CMP_W-1:0]   limit_ext;
   logic [CNT_W-1:0]   lim;
   logic [CNT_W-1:0]   free_slots;
   logic               put_ok;
   logic [KEY_W-1:0]   put_code;
   logic [CNT_W:0]     slot_sum;
   logic [CNT_W:0]     slot_wrap;
   logic [CNT_W-1:0]   slot_next;
   logic               get_ok;
   logic [KEY_W-1:0]   rd_data;
   logic               wr_en;

   assign limit_ext = CMP_W'(limit_ff);
   assign lim = (limit_ext > CMP_W'(MAX_DEPTH)) ? CNT_W'(MAX_DEPTH) : CNT_W'(limit_ext);
   assign free_slots = lim - count_ff;

   always_comb begin
      put_ok   = 1'b1;
      put_code = key_ff;
      if (free_slots == '0) begin
         put_ok = 1'b0;
      end else if (((key_ff & DOWN_MASK) != '0) && (free_slots <= (lim >> 1))) begin
         put_ok = 1'b0;
      end else if (free_slots == CNT_W'(1)) begin
         // Last slot is reserved for a release-all event.
         if ((last_down_ff & RA_MASK) != '0) begin
            put_ok = 1'b0;
         end
         put_code = ((key_ff == last_down_ff) ? key_ff : '0) | RA_MASK;
      end
   end

   // read_slot + count stays below twice the limit: one conditional subtract.
   assign slot_sum  = (CNT_W + 1)'(read_slot_ff) + (CNT_W + 1)'(count_ff);
   assign slot_wrap = (slot_sum >= (CNT_W + 1)'(lim)) ? slot_sum - (CNT_W + 1)'(lim)
                                                      : slot_sum;
   assign slot_next = (CNT_W'(read_slot_ff) + CNT_W'(1) == lim) ? '0
                                                               : CNT_W'(read_slot_ff) + CNT_W'(1);

   assign get_ok = (count_ff != '0) && (lim != '0);
   assign wr_en  = cmd.execute && (cmd_ff == CMD_PUT) && put_ok;

   kef_ram #(
      .WIDTH (KEY_W),
      .DEPTH (MAX_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (IDX_W'(slot_wrap)),
      .wr_data (put_code),
      .rd_addr (read_slot_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      accepted_in  = 1'b0;
      key_valid_in = 1'b0;
      key_out_in   = '0;
      if (cmd_ff == CMD_PUT) begin
         if (put_ok) begin
            accepted_in = 1'b1;
            key_out_in  = put_code;
         end
      end else if (get_ok) begin
         key_valid_in = 1'b1;
         key_out_in   = rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         read_slot_ff <= '0;
         count_ff     <= '0;
         last_down_ff <= '0;
      end else if (cmd.cfg_write) begin
         limit_ff     <= csr_data;
         read_slot_ff <= '0;
         count_ff     <= '0;
      end else if (cmd.execute) begin
         if (wr_en) begin
            count_ff <= count_ff + CNT_W'(1);
            if ((put_code & DOWN_MASK) != '0) begin
               last_down_ff <= put_code & ~DOWN_MASK;
            end else begin
               last_down_ff <= put_code & RA_MASK;
            end
         end else if ((cmd_ff == CMD_GET) && get_ok) begin
            count_ff     <= count_ff - CNT_W'(1);
            read_slot_ff <= IDX_W'(slot_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff <= req_command;
         key_ff <= req_key_code;
      end
      if (cmd.execute) begin
         accepted_ff  <= accepted_in;
         key_valid_ff <= key_valid_in;
         key_out_ff   <= key_out_in;
      end
   end

   assign rsp_accepted  = accepted_ff;
   assign rsp_key_valid = key_valid_ff;
   assign rsp_key_out   = key_out_ff;

   a_count_in_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= lim)
      else $error("entry count exceeds active limit");

   a_slot_in_limit: assert property (@(posedge clock) disable iff (reset)
      (read_slot_ff == '0) || (CNT_W'(read_slot_ff) < lim))
      else $error("read slot outside active limit");

   a_write_needs_room: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("stored put did not advance the count");

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for key_event_fifo_with_release_reserve.
// Drives put/get transactions and limit writes, predicts each response.
// Depends on kef_pkg, kef_if and the RTL top level.
`timescale 1ns / 1ps

module testbench;
   import kef_pkg::*;

   localparam int          SLOT_COUNT     = MAX_DEPTH_DEF;
   localparam logic [31:0] DOWN_MASK      = 32'h1 << DOWN_BIT_DEF;
   localparam logic [31:0] RELEASE_MASK   = 32'h1 << RELEASE_BIT_DEF;
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          RANDOM_ITEMS   = 650;

   typedef struct packed {
      logic        accepted;
      logic        key_valid;
      logic [31:0] key_out;
   } key_result_type;

   typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SLOW} rx_mode_type;

   logic clock;
   logic reset;

   kef_req_if req_ch();
   kef_rsp_if rsp_ch();
   kef_csr_if csr_ch();

   key_event_fifo_with_release_reserve u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Shadow copy of the queue state
   logic [31:0]        event_slots [SLOT_COUNT];
   int unsigned        head_slot;
   int unsigned        stored_count;
   logic [31:0]        last_down_key;
   logic [LIMIT_W-1:0] limit_setting;

   key_result_type pending_key_results[$];

   int error_count;
   int n_stored, n_dropped, n_reserve, n_fetched, n_empty, n_limit_writes;
   int burst_left;
   int idle_cycles;

   rx_mode_type rx_mode;
   int          rx_left;
   int          rx_tick;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Queue behavior for one accepted transaction; updates the shadow state.
   function automatic key_result_type predict_key_event(input logic cmd,
                                                        input logic [31:0] code_in);
      key_result_type res;
      int unsigned lim, used, free_slots, slot;
      logic [31:0] code;
      res  = '0;
      code = code_in;
      lim  = (limit_setting > SLOT_COUNT) ? SLOT_COUNT : limit_setting;
      if (cmd == CMD_PUT) begin
         used       = (stored_count > lim) ? lim : stored_count;
         free_slots = lim - used;
         if (free_slots == 0) begin
            n_dropped++;
         end else if ((code & DOWN_MASK) != 0 && free_slots <= (lim >> 1)) begin
            n_dropped++;
         end else if (free_slots == 1 && (last_down_key & RELEASE_MASK) != 0) begin
            n_dropped++;
         end else begin
            // last slot is held back for a release-all event
            if (free_slots == 1) begin
               if (code != last_down_key)
                  code = '0;
               code = code | RELEASE_MASK;
               n_reserve++;
            end
            slot = (head_slot + stored_count) % lim;
            event_slots[slot] = code;
            stored_count++;
            if ((code & DOWN_MASK) != 0)
               last_down_key = code & ~DOWN_MASK;
            else
               last_down_key = code & RELEASE_MASK;
            res.accepted = 1'b1;
            res.key_out  = code;
            n_stored++;
         end
      end else begin
         if (stored_count == 0 || lim == 0) begin
            n_empty++;
         end else begin
            res.key_valid = 1'b1;
            res.key_out   = event_slots[head_slot % lim];
            head_slot     = (head_slot + 1) % lim;
            stored_count--;
            n_fetched++;
         end
      end
      return res;
   endfunction

   function automatic logic [31:0] pick_key_code();
      logic [31:0] code;
      case ($urandom_range(0, 9))
         0, 1:    code = $urandom;
         2, 3:    code = $urandom | DOWN_MASK;
         4:       code = ($urandom & ~DOWN_MASK) | RELEASE_MASK;
         5:       code = last_down_key;
         6:       code = last_down_key | DOWN_MASK;
         7:       code = $urandom_range(0, 255);
         8:       code = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
         default: code = $urandom & ~(DOWN_MASK | RELEASE_MASK);
      endcase
      return code;
   endfunction

   // Entered and left just after a falling edge.
   task automatic send_request(input logic cmd, input logic [31:0] code);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_ch.valid    = 1'b1;
      req_ch.command  = cmd;
      req_ch.key_code = code;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      pending_key_results.push_back(predict_key_event(cmd, code));
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_ch.valid = 1'b0;
      while (pending_key_results.size() != 0)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      drain_results();
      csr_ch.valid = 1'b1;
      csr_ch.data  = value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      limit_setting = value;
      head_slot     = 0;
      stored_count  = 0;
      n_limit_writes++;
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic test_empty_get();
      send_request(CMD_GET, 32'h0);
   endtask

   // Reset limit of 7: down-key cutoff, full drop and release-all rewrite.
   task automatic test_fill_and_reserve();
      logic [31:0] codes [9];
      codes = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h2000_0041, 32'h2000_0042, 32'h2000_0043,
                32'h1000_0000, 32'h0000_0001, 32'h0000_0055, 32'h0000_0009};
      foreach (codes[i])
         send_request(CMD_PUT, codes[i]);
      send_request(CMD_GET, 32'hFFFF_FFFF);
      send_request(CMD_GET, 32'h0);
   endtask

   task automatic test_zero_limit();
      write_limit(LIMIT_W'(0));
      send_request(CMD_PUT, 32'h0000_0005);
      send_request(CMD_GET, 32'h0);
   endtask

   // Last slot keeps the key when it matches the previous down key; a second
   // release-all in a row is dropped.
   task automatic test_key_kept();
      write_limit(LIMIT_W'(2));
      send_request(CMD_PUT, 32'h2000_00AB);
      send_request(CMD_PUT, 32'h0000_00AB);
      send_request(CMD_GET, 32'h0);
      send_request(CMD_PUT, 32'h0000_0003);
      send_request(CMD_GET, 32'h0);
      send_request(CMD_GET, 32'h0);
   endtask

   task automatic test_saturated_limit();
      write_limit(LIMIT_W'(127));
      send_request(CMD_PUT, 32'h2000_0001);
      send_request(CMD_PUT, 32'h1000_0001);
      send_request(CMD_GET, 32'h0);
   endtask

   task automatic test_random_traffic(input int item_goal);
      int sent, phase_len, put_pct, eff, n;
      logic [LIMIT_W-1:0] lim_sel;
      logic cmd;
      sent = 0;
      while (sent < item_goal) begin
         case ($urandom_range(0, 9))
            0:       lim_sel = LIMIT_W'(1);
            1:       lim_sel = LIMIT_W'(2);
            2:       lim_sel = LIMIT_W'(3);
            3:       lim_sel = LIMIT_W'($urandom_range(4, 8));
            4:       lim_sel = LIMIT_W'($urandom_range(9, 40));
            5:       lim_sel = LIMIT_W'(64);
            6:       lim_sel = LIMIT_W'($urandom_range(65, 127));
            7:       lim_sel = LIMIT_W'(0);
            8:       lim_sel = LIMIT_W'($urandom_range(0, 127));
            default: lim_sel = LIMIT_RESET;
         endcase
         write_limit(lim_sel);
         eff = (lim_sel > SLOT_COUNT) ? SLOT_COUNT : lim_sel;
         if (eff == 0)
            phase_len = 6;
         else if (eff > 32)
            phase_len = $urandom_range(60, 120);
         else
            phase_len = $urandom_range(15, 40);
         case ($urandom_range(0, 3))
            0:       put_pct = 30;
            1:       put_pct = 50;
            2:       put_pct = 70;
            default: put_pct = 85;
         endcase
         for (n = 0; n < phase_len && sent < item_goal; n++) begin
            if ($urandom_range(0, 49) == 0)
               drain_results();
            cmd = ($urandom_range(0, 99) < put_pct) ? CMD_PUT : CMD_GET;
            send_request(cmd, (cmd == CMD_PUT) ? pick_key_code() : 32'($urandom));
            sent++;
         end
      end
   endtask

   // Response checker
   always @(posedge clock) begin
      key_result_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_key_results.size() == 0) begin
            $error("response with no transaction outstanding");
            error_count++;
         end else begin
            want = pending_key_results.pop_front();
            if (rsp_ch.accepted !== want.accepted) begin
               $error("accepted: expected %0b, got %0b", want.accepted, rsp_ch.accepted);
               error_count++;
            end
            if (rsp_ch.key_valid !== want.key_valid) begin
               $error("key_valid: expected %0b, got %0b", want.key_valid, rsp_ch.key_valid);
               error_count++;
            end
            if (rsp_ch.key_out !== want.key_out) begin
               $error("key_out: expected %08h, got %08h", want.key_out, rsp_ch.key_out);
               error_count++;
            end
         end
      end
   end

   // Response back-pressure, switching at random among open, random and slow modes
   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 2));
         rx_left = $urandom_range(20, 80);
      end
      rx_left--;
      rx_tick++;
      case (rx_mode)
         RX_OPEN:   rsp_ch.ready = 1'b1;
         RX_RANDOM: rsp_ch.ready = ($urandom_range(0, 99) < 60);
         default:   rsp_ch.ready = (rx_tick % 5 == 0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("testbench: FAIL");
            $finish;
         end
      end
   end

   initial begin
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.command  = CMD_PUT;
      req_ch.key_code = '0;
      rsp_ch.ready    = 1'b0;
      csr_ch.valid    = 1'b0;
      csr_ch.data     = '0;
      head_slot       = 0;
      stored_count    = 0;
      last_down_key   = '0;
      limit_setting   = LIMIT_RESET;
      error_count     = 0;
      n_stored        = 0;
      n_dropped       = 0;
      n_reserve       = 0;
      n_fetched       = 0;
      n_empty         = 0;
      n_limit_writes  = 0;
      burst_left      = 0;
      idle_cycles     = 0;
      rx_mode         = RX_OPEN;
      rx_left         = 0;
      rx_tick         = 0;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      test_empty_get();
      test_fill_and_reserve();
      test_zero_limit();
      test_key_kept();
      test_saturated_limit();
      test_random_traffic(RANDOM_ITEMS);

      drain_results();
      repeat (10) @(posedge clock);
      $display("covered %0d stored puts (%0d via release reserve), %0d dropped puts",
               n_stored, n_reserve, n_dropped);
      $display("covered %0d gets with data, %0d gets on empty queue, %0d limit writes",
               n_fetched, n_empty, n_limit_writes);
      if (error_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
